@@ src/sld_pkg.sv @@
// Shared types and constants for the skew line distance pipeline.
// No dependencies; imported by sld_root_stage and skew_line_distance_core.
`timescale 1ns / 1ps
`default_nettype none
package sld_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int DIST_WIDTH      = 25;

	typedef struct packed {
		logic valid;
		logic par;
	} ctl_t;

endpackage
`default_nettype wire

@@ src/skew_line_distance_core.sv @@
// Top level: shortest distance between two 3D lines, fully pipelined.
// Depends on sld_pkg and sld_root_stage.
//
// channel   handshake            payload
// input     start, busy          dir1_*, dir2_*, pt1_*, pt2_*
// result    done (strobe)        distance, parallel_flag
//
// One transaction accepted per cycle; busy is always low.
// The pipeline has six arithmetic stages (cross product,
// dot and norm products, sums, squaring), one stage per result bit, and
// an output register. Reset clears only the valid bits and the root stage ctl words.
// The receiver cannot stall; each result shows for one cycle with done.
`timescale 1ns / 1ps
`default_nettype none
module skew_line_distance_core import sld_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] dir1_x,
	input  wire logic signed [COORD_WIDTH-1:0] dir1_y,
	input  wire logic signed [COORD_WIDTH-1:0] dir1_z,
	input  wire logic signed [COORD_WIDTH-1:0] dir2_x,
	input  wire logic signed [COORD_WIDTH-1:0] dir2_y,
	input  wire logic signed [COORD_WIDTH-1:0] dir2_z,
	input  wire logic signed [COORD_WIDTH-1:0] pt1_x,
	input  wire logic signed [COORD_WIDTH-1:0] pt1_y,
	input  wire logic signed [COORD_WIDTH-1:0] pt1_z,
	input  wire logic signed [COORD_WIDTH-1:0] pt2_x,
	input  wire logic signed [COORD_WIDTH-1:0] pt2_y,
	input  wire logic signed [COORD_WIDTH-1:0] pt2_z,
	output logic                               done,
	output logic             [DIST_WIDTH-1:0]  distance,
	output logic                               parallel_flag
);

	localparam int CW  = COORD_WIDTH;
	localparam int QW  = DIST_WIDTH;
	localparam int PCW = 2 * CW;
	localparam int DW  = 3 * CW + 2;
	localparam int DSW = DW + 1;
	localparam int NW  = 4 * CW + 2;
	localparam int PW  = NW + QW;
	localparam int H   = (DW + 1) / 2;
	localparam int HW  = DW - H;
	localparam int XW  = 2 * DW + 2 * FRAC_BITS;
	localparam int RW  = ((XW > NW + 2 * QW) ? XW : NW + 2 * QW) + 1;
	localparam int LAT = QW + 7;

	// stage 1: six direction products and point difference
	logic                valid_s1;
	logic signed [PCW-1:0] m_s1 [6];
	logic signed [CW:0]    d_s1 [3];

	// stage 2: cross product
	logic                valid_s2;
	logic signed [PCW:0] c_s2 [3];
	logic signed [CW:0]  d_s2 [3];

	// stage 3: dot and norm products
	logic              valid_s3;
	logic              par_s3;
	logic [DW-3:0]     dp_s3 [3];
	logic              dneg_s3 [3];
	logic [2*PCW-1:0]  csq_s3 [3];

	// stage 4: sums
	logic                valid_s4;
	logic                par_s4;
	logic signed [DSW-1:0] dot_s4;
	logic [NW-1:0]       nsq_s4;

	// stage 5: squaring partial products
	logic              valid_s5;
	logic              par_s5;
	logic [2*HW-1:0]   hh_s5;
	logic [DW-1:0]     hl_s5;
	logic [2*H-1:0]    ll_s5;
	logic [NW-1:0]     nsq_s5;

	// stage 6: scaled square of the dot product
	logic              valid_s6;
	logic              par_s6;
	logic [RW-1:0]     x_s6;
	logic [NW-1:0]     nsq_s6;

	logic [PCW-1:0]    cmag [3];
	logic              cneg [3];
	logic [CW-1:0]     dmag [3];
	logic [DSW-1:0]    term [3];
	logic [DW-1:0]     dotmag;

	ctl_t              ctl_c  [QW+1];
	logic [RW-1:0]     rem_c  [QW+1];
	logic [PW-1:0]     part_c [QW+1];
	logic [NW-1:0]     nsq_c  [QW+1];
	logic [QW-1:0]     quo_c  [QW+1];

	logic              done_q;
	logic              par_q;
	logic [QW-1:0]     distance_q;

	assign busy = 1'b0;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cneg[i] = c_s2[i][PCW];
			cmag[i] = cneg[i] ? PCW'(-c_s2[i]) : PCW'(c_s2[i]);
			dmag[i] = d_s2[i][CW] ? CW'(-d_s2[i]) : CW'(d_s2[i]);
			term[i] = dneg_s3[i] ? DSW'(-{3'b000, dp_s3[i]}) : DSW'({3'b000, dp_s3[i]});
		end
		dotmag = dot_s4[DSW-1] ? DW'(-dot_s4) : DW'(dot_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		m_s1[0] <= dir1_y * dir2_z;
		m_s1[1] <= dir1_z * dir2_y;
		m_s1[2] <= dir1_z * dir2_x;
		m_s1[3] <= dir1_x * dir2_z;
		m_s1[4] <= dir1_x * dir2_y;
		m_s1[5] <= dir1_y * dir2_x;
		d_s1[0] <= (CW+1)'(pt2_x) - (CW+1)'(pt1_x);
		d_s1[1] <= (CW+1)'(pt2_y) - (CW+1)'(pt1_y);
		d_s1[2] <= (CW+1)'(pt2_z) - (CW+1)'(pt1_z);

		for (int i = 0; i < 3; i++) begin
			c_s2[i] <= (PCW+1)'(m_s1[2*i]) - (PCW+1)'(m_s1[2*i+1]);
			d_s2[i] <= d_s1[i];
		end

		par_s3 <= (c_s2[0] == '0) && (c_s2[1] == '0) && (c_s2[2] == '0);
		for (int i = 0; i < 3; i++) begin
			dp_s3[i]   <= dmag[i] * cmag[i];
			dneg_s3[i] <= d_s2[i][CW] ^ cneg[i];
			csq_s3[i]  <= cmag[i] * cmag[i];
		end

		par_s4 <= par_s3;
		dot_s4 <= term[0] + term[1] + term[2];
		nsq_s4 <= NW'(csq_s3[0]) + NW'(csq_s3[1]) + NW'(csq_s3[2]);

		par_s5 <= par_s4;
		nsq_s5 <= nsq_s4;
		hh_s5  <= dotmag[DW-1:H] * dotmag[DW-1:H];
		hl_s5  <= dotmag[DW-1:H] * dotmag[H-1:0];
		ll_s5  <= dotmag[H-1:0] * dotmag[H-1:0];

		par_s6 <= par_s5;
		nsq_s6 <= nsq_s5;
		x_s6   <= ((RW'(hh_s5) << (2 * H)) + (RW'(hl_s5) << (H + 1)) + RW'(ll_s5))
			<< (2 * FRAC_BITS);
	end

	always_comb begin
		ctl_c[0].valid = valid_s6;
		ctl_c[0].par   = par_s6;
		rem_c[0]       = x_s6;
		part_c[0]      = '0;
		nsq_c[0]       = nsq_s6;
		quo_c[0]       = '0;
	end

	for (genvar j = 0; j < QW; j++) begin : g_root
		sld_root_stage #(
			.NW (NW),
			.QW (QW),
			.RW (RW),
			.K  (QW - 1 - j)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl_c[j]),
			.rem    (rem_c[j]),
			.part   (part_c[j]),
			.nsq    (nsq_c[j]),
			.quo    (quo_c[j]),
			.ctl_q  (ctl_c[j+1]),
			.rem_q  (rem_c[j+1]),
			.part_q (part_c[j+1]),
			.nsq_q  (nsq_c[j+1]),
			.quo_q  (quo_c[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[QW].valid;
		end
	end

	// drop the search result for parallel directions
	always_ff @(posedge clk) begin
		par_q      <= ctl_c[QW].par;
		distance_q <= ctl_c[QW].par ? '0 : quo_c[QW];
	end

	assign done          = done_q;
	assign distance      = distance_q;
	assign parallel_flag = par_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a transaction accepted LAT cycles earlier");

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && parallel_flag) |-> (distance == '0))
		else $error("parallel result with nonzero distance");

	a_norm_par: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (par_s4 == (nsq_s4 == '0)))
		else $error("norm and parallel flag disagree");

endmodule
`default_nettype wire

@@ src/sld_root_stage.sv @@
// One bit of the restoring quotient search: keeps q^2 * nsq <= x as a running residual.
// Depends on sld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sld_root_stage import sld_pkg::*; #(
	parameter int NW = 4 * COORD_WIDTH_DEF + 2,
	parameter int QW = DIST_WIDTH,
	parameter int RW = 2 * (3 * COORD_WIDTH_DEF + 2) + 2 * FRAC_BITS_DEF + 1,
	parameter int K  = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  ctl_t                 ctl,
	input  wire logic [RW-1:0]   rem,
	input  wire logic [NW+QW-1:0] part,
	input  wire logic [NW-1:0]   nsq,
	input  wire logic [QW-1:0]   quo,
	output ctl_t                 ctl_q,
	output logic      [RW-1:0]   rem_q,
	output logic      [NW+QW-1:0] part_q,
	output logic      [NW-1:0]   nsq_q,
	output logic      [QW-1:0]   quo_q
);

	localparam int PW = NW + QW;

	logic [RW-1:0] trial;
	logic          take;

	always_comb begin
		trial = (RW'(part) << (K + 1)) + (RW'(nsq) << (2 * K));
		take  = (trial <= rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		nsq_q <= nsq;
		if (take) begin
			rem_q  <= rem - trial;
			part_q <= part + (PW'(nsq) << K);
			quo_q  <= quo | (QW'(1) << K);
		end else begin
			rem_q  <= rem;
			part_q <= part;
			quo_q  <= quo;
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/skew_line_distance_checker.sv @@
// Checker for skew_line_distance_core: predicts every distance from the accepted inputs
// and compares it against the done strobe. Depends on sld_pkg.
`timescale 1ns / 1ps
module skew_line_distance_checker import sld_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic signed [15:0]            dir1_x,
	input  wire logic signed [15:0]            dir1_y,
	input  wire logic signed [15:0]            dir1_z,
	input  wire logic signed [15:0]            dir2_x,
	input  wire logic signed [15:0]            dir2_y,
	input  wire logic signed [15:0]            dir2_z,
	input  wire logic signed [15:0]            pt1_x,
	input  wire logic signed [15:0]            pt1_y,
	input  wire logic signed [15:0]            pt1_z,
	input  wire logic signed [15:0]            pt2_x,
	input  wire logic signed [15:0]            pt2_y,
	input  wire logic signed [15:0]            pt2_z,
	input  wire logic                          done,
	input  wire logic        [DIST_WIDTH-1:0]  distance,
	input  wire logic                          parallel_flag,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 parallel_seen,
	output int                                 result_count
);

	typedef struct {
		logic [DIST_WIDTH-1:0] span;
		logic                  par;
	} line_gap_t;

	line_gap_t gap_q[$];

	function automatic line_gap_t predict_gap();
		longint    a[3], b[3], d[3], c[3], dot;
		logic [255:0] nsq, x, lhs, cw, dw;
		logic [24:0]  q, cand;
		line_gap_t    r;
		a = '{dir1_x, dir1_y, dir1_z};
		b = '{dir2_x, dir2_y, dir2_z};
		d = '{longint'(pt2_x) - pt1_x, longint'(pt2_y) - pt1_y, longint'(pt2_z) - pt1_z};
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		r.span = '0;
		r.par  = 1'b1;
		if (c[0] == 0 && c[1] == 0 && c[2] == 0)
			return r;
		dot = 0;
		nsq = '0;
		for (int i = 0; i < 3; i++) begin
			dot += d[i] * c[i];
			cw = (c[i] < 0) ? -c[i] : c[i];
			nsq += cw * cw;
		end
		dw = (dot < 0) ? -dot : dot;
		x = (dw * dw) << (2 * FRAC_BITS_DEF);
		q = '0;
		for (int bitpos = 24; bitpos >= 0; bitpos--) begin
			cand = q | (25'd1 << bitpos);
			lhs = 256'(cand) * 256'(cand) * nsq;
			if (lhs <= x)
				q = cand;
		end
		r.span = q;
		r.par  = 1'b0;
		return r;
	endfunction

	initial begin
		fail_count    = 0;
		parallel_seen = 0;
		result_count  = 0;
	end

	assign pending = gap_q.size();

	always @(posedge clk) begin
		line_gap_t exp_r;
		if (arst_n && start && !busy)
			gap_q.push_back(predict_gap());
		if (arst_n && done) begin
			result_count++;
			if (gap_q.size() == 0) begin
				$display("%0t: unexpected result distance=%0d parallel_flag=%0b",
					$time, distance, parallel_flag);
				fail_count++;
			end else begin
				exp_r = gap_q.pop_front();
				if (exp_r.par)
					parallel_seen++;
				if (distance !== exp_r.span) begin
					$display("%0t: distance expected %0d actual %0d",
						$time, exp_r.span, distance);
					fail_count++;
				end
				if (parallel_flag !== exp_r.par) begin
					$display("%0t: parallel_flag expected %0b actual %0b",
						$time, exp_r.par, parallel_flag);
					fail_count++;
				end
			end
		end
	end

endmodule

@@ tb/sv/tb_skew_line_distance_core.sv @@
// Testbench top for skew_line_distance_core: drives directed and random line pairs
// with random idle bursts and reports the verdict. Depends on sld_pkg and the checker.
`timescale 1ns / 1ps
module tb_skew_line_distance_core;
	import sld_pkg::*;

	typedef struct {
		logic signed [15:0] v[12];
	} line_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] f[12];
	logic busy, done, parallel_flag;
	logic [DIST_WIDTH-1:0] distance;
	int fail_count, pending, parallel_seen, result_count;
	int sent = 0;

	initial foreach (f[i]) f[i] = '0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	skew_line_distance_core dut (
		.clk, .arst_n, .start, .busy,
		.dir1_x(f[0]), .dir1_y(f[1]), .dir1_z(f[2]),
		.dir2_x(f[3]), .dir2_y(f[4]), .dir2_z(f[5]),
		.pt1_x(f[6]), .pt1_y(f[7]), .pt1_z(f[8]),
		.pt2_x(f[9]), .pt2_y(f[10]), .pt2_z(f[11]),
		.done, .distance, .parallel_flag
	);

	skew_line_distance_checker chk (
		.clk, .arst_n, .start, .busy,
		.dir1_x(f[0]), .dir1_y(f[1]), .dir1_z(f[2]),
		.dir2_x(f[3]), .dir2_y(f[4]), .dir2_z(f[5]),
		.pt1_x(f[6]), .pt1_y(f[7]), .pt1_z(f[8]),
		.pt2_x(f[9]), .pt2_y(f[10]), .pt2_z(f[11]),
		.done, .distance, .parallel_flag,
		.fail_count, .pending, .parallel_seen, .result_count
	);

	task automatic send_pair(input line_pair_t p, input bit allow_idle);
		int gap;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		foreach (f[i]) f[i] <= p.v[i];
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic line_pair_t make_pair(input int d1[3], input int d2[3],
		input int p1[3], input int p2[3]);
		line_pair_t p;
		for (int i = 0; i < 3; i++) begin
			p.v[i]     = 16'(d1[i]);
			p.v[3 + i] = 16'(d2[i]);
			p.v[6 + i] = 16'(p1[i]);
			p.v[9 + i] = 16'(p2[i]);
		end
		return p;
	endfunction

	function automatic line_pair_t random_pair();
		line_pair_t p;
		int sel, k, lim;
		sel = $urandom_range(0, 9);
		lim = (sel < 4) ? 65535 : (sel < 7) ? 255 : 15;
		foreach (p.v[i])
			p.v[i] = (lim == 65535) ? 16'($urandom) : 16'($urandom_range(0, 2 * lim) - lim);
		if (sel == 9) begin
			// parallel directions: scale the first
			k = $urandom_range(0, 200) - 100;
			for (int i = 0; i < 3; i++) begin
				p.v[i]     = 16'($urandom_range(0, 300) - 150);
				p.v[3 + i] = 16'(p.v[i] * k);
			end
		end
		return p;
	endfunction

	initial begin
		line_pair_t dirs[$];
		int n_rand;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		dirs.push_back(make_pair('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{5, 5, 5}));
		dirs.push_back(make_pair('{1, 2, 3}, '{2, 4, 6}, '{0, 0, 0}, '{9, 9, 9}));
		dirs.push_back(make_pair('{1, 2, 3}, '{-3, -6, -9}, '{1, 1, 1}, '{0, 0, 0}));
		dirs.push_back(make_pair('{1, 0, 0}, '{0, 1, 0}, '{0, 0, -32768}, '{0, 0, 32767}));
		dirs.push_back(make_pair('{1, 0, 0}, '{0, 1, 0}, '{0, 0, 32767}, '{0, 0, -32768}));
		dirs.push_back(make_pair('{1, 1, 1}, '{1, -1, 0}, '{-32768, -32768, -32768},
			'{32767, 32767, 32767}));
		dirs.push_back(make_pair('{-32768, -32768, -32768}, '{32767, -32768, 32767},
			'{32767, -32768, 32767}, '{-32768, 32767, -32768}));
		dirs.push_back(make_pair('{32767, 32767, 32767}, '{-32768, 32767, 0},
			'{-1, -1, -1}, '{0, 0, 0}));
		dirs.push_back(make_pair('{-32768, 0, 0}, '{0, -32768, 0}, '{0, 0, 0}, '{0, 0, 0}));
		dirs.push_back(make_pair('{3, 0, 0}, '{0, 7, 0}, '{0, 0, 0}, '{0, 0, 1}));
		dirs.push_back(make_pair('{1, 0, 0}, '{0, 1, 0}, '{0, 0, 0}, '{0, 0, 0}));
		dirs.push_back(make_pair('{1, 2, 0}, '{2, 1, 0}, '{5, -7, 3}, '{-11, 13, -2}));
		dirs.push_back(make_pair('{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1},
			'{-1, -1, -1}));
		foreach (dirs[i]) send_pair(dirs[i], 1'b1);

		n_rand = 950;
		for (int i = 0; i < n_rand; i++)
			send_pair(random_pair(), i < n_rand - 100);
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DIST_WIDTH + 12) @(posedge clk);
		$display("Sent %0d line pairs (%0d directed), checked %0d results, %0d parallel.",
			sent, dirs.size(), result_count, parallel_seen);
		if (fail_count == 0)
			$display("skew_line_distance_core: match");
		else
			$display("skew_line_distance_core: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout waiting for results.");
		$display("skew_line_distance_core: mismatch");
		$finish;
	end

endmodule

@@ skew_line_distance_core.f @@
src/sld_pkg.sv
src/sld_root_stage.sv
src/skew_line_distance_core.sv
tb/sv/skew_line_distance_checker.sv
tb/sv/tb_skew_line_distance_core.sv
